// ===== src/eth_ipv4_udp_header_builder_assert.svh =====
// Assertion macros used by the checker of the header builder.
// Both macros sample on clock and are switched off while reset is high.
`ifndef ETH_IPV4_UDP_HEADER_BUILDER_ASSERT_SVH
`define ETH_IPV4_UDP_HEADER_BUILDER_ASSERT_SVH

// Same-cycle implication.
`define EHB_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define EHB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ehb_pkg.sv =====
// Types and constants of the Ethernet/IPv4/UDP header builder.
// Used by the preparation pipeline, the byte cells and the top level.
`default_nettype none
package ehb_pkg;

   localparam int HDR_BYTES = 42;
   localparam int POS_W     = 6;
   localparam int SUM_W     = 18;
   localparam int FOLD_W    = 17;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_VER_IHL     = 8'h45;
   localparam logic [7:0]  IP_TOS         = 8'h00;
   localparam logic [15:0] IP_IDENT       = 16'h0001;
   localparam logic [15:0] IP_FRAG        = 16'h0000;
   localparam logic [7:0]  IP_TTL         = 8'd16;
   localparam logic [15:0] IP_HDR_LEN     = 16'd20;
   localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
   localparam logic [15:0] UDP_CSUM       = 16'h0000;

   // Address and port fields that pass straight through to the header.
   typedef struct packed {
      logic [47:0] dest_mac;
      logic [7:0]  protocol_number;
      logic [31:0] dest_ip;
      logic [31:0] source_ip;
      logic [15:0] dest_port;
      logic [15:0] source_port;
   } addr_type;

   typedef struct packed {
      addr_type    addr;
      logic [15:0] payload_length;
   } req_type;

   // Everything needed to lay out one header.
   typedef struct packed {
      addr_type            addr;
      logic [15:0]         ip_len;
      logic [15:0]         udp_len;
      logic [FOLD_W-1:0]   csum_fold;
   } frame_type;

   typedef struct packed {
      logic [7:0]       data;
      logic [POS_W-1:0] pos;
      logic             last;
   } cell_type;

endpackage
`default_nettype wire

// ===== src/ehb_prep.sv =====
// Two-stage pipeline that forms the length fields and the folded IPv4 checksum sum.
// Depends on ehb_pkg.
`default_nettype none
module ehb_prep (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire ehb_pkg::req_type   in_req,
   output logic                    out_valid,
   input  wire logic               out_take,
   output ehb_pkg::frame_type      out_frame
);
   import ehb_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   addr_type          s1_addr_ff, s1_addr_in;
   logic [15:0]       s1_ip_len_ff, s1_ip_len_in;
   logic [15:0]       s1_udp_len_ff, s1_udp_len_in;
   logic [SUM_W-1:0]  s1_sum_a_ff, s1_sum_a_in;
   logic [SUM_W-1:0]  s1_sum_b_ff, s1_sum_b_in;
   logic              s2_valid_ff, s2_valid_in;
   frame_type         s2_frame_ff, s2_frame_in;
   logic              s1_free, s2_free;
   logic [SUM_W:0]    total;

   assign s2_free  = !s2_valid_ff || out_take;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign in_ready = s1_free;

   always_comb begin
      s1_valid_in   = s1_free ? in_valid : s1_valid_ff;
      s1_addr_in    = in_req.addr;
      s1_ip_len_in  = in_req.payload_length + UDP_HDR_LEN + IP_HDR_LEN;
      s1_udp_len_in = in_req.payload_length + UDP_HDR_LEN;
      // Address words of the IPv4 header, plus the constant words and the
      // TTL/protocol word. Total length joins in the next stage.
      s1_sum_a_in   = SUM_W'(in_req.addr.source_ip[31:16]) + SUM_W'(in_req.addr.source_ip[15:0])
                    + SUM_W'(in_req.addr.dest_ip[31:16]);
      s1_sum_b_in   = SUM_W'(in_req.addr.dest_ip[15:0]) + SUM_W'({IP_TTL, in_req.addr.protocol_number})
                    + SUM_W'({IP_VER_IHL, IP_TOS}) + SUM_W'(IP_IDENT) + SUM_W'(IP_FRAG);
   end

   always_comb begin
      total       = (SUM_W+1)'(s1_sum_a_ff) + (SUM_W+1)'(s1_sum_b_ff) + (SUM_W+1)'(s1_ip_len_ff);
      s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
      s2_frame_in.addr      = s1_addr_ff;
      s2_frame_in.ip_len    = s1_ip_len_ff;
      s2_frame_in.udp_len   = s1_udp_len_ff;
      // First end-around fold; the second one is a single increment at load.
      s2_frame_in.csum_fold = FOLD_W'(total[15:0]) + FOLD_W'(total[SUM_W:16]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_addr_ff    <= s1_addr_in;
         s1_ip_len_ff  <= s1_ip_len_in;
         s1_udp_len_ff <= s1_udp_len_in;
         s1_sum_a_ff   <= s1_sum_a_in;
         s1_sum_b_ff   <= s1_sum_b_in;
      end
      if (s2_free) begin
         s2_frame_ff <= s2_frame_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_frame = s2_frame_ff;

endmodule
`default_nettype wire

// ===== src/ehb_cell.sv =====
// One byte cell of the output shift chain: loads in parallel, shifts towards the output.
// Depends on ehb_pkg.
`default_nettype none
module ehb_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift,
   input  wire logic              load,
   input  wire ehb_pkg::cell_type load_data,
   input  wire logic              next_valid,
   input  wire ehb_pkg::cell_type next_data,
   output logic                   cell_valid,
   output ehb_pkg::cell_type      cell_data
);
   import ehb_pkg::*;

   logic     valid_ff, valid_in;
   cell_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (shift) begin
         valid_in = next_valid;
         data_in  = next_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_valid = valid_ff;
   assign cell_data  = data_ff;

endmodule
`default_nettype wire

// ===== src/eth_ipv4_udp_header_builder.sv =====
// A request beat passes the prep stages and is then loaded into the byte chain.
// Throughput: one header beat per cycle while rsp_tready holds; the next request's
// header, if ready, is loaded into the byte chain in the cycle its last byte is taken,
// so frames follow one another without a gap. The chain has 42 cells, one per byte.
// Reset (synchronous, active high) empties the pipeline and chain and clears source_mac.
`default_nettype none
module eth_ipv4_udp_header_builder (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [47:0]  csr_wr_data,    // source_mac
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // payload_length, source_port, dest_port, source_ip, dest_ip, protocol_number, dest_mac
   input  wire logic [167:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata,      // header_byte, byte_position, 2 bits zero
   output logic              rsp_tlast       // last_byte
);
   import ehb_pkg::*;

   logic [47:0] source_mac_ff, source_mac_in;
   req_type     req;
   logic        frame_valid;
   frame_type   frame;
   logic        shift, load;
   logic [15:0] csum;
   logic [15:0] csum_sum;
   logic [7:0]  hdr [HDR_BYTES];
   logic        cvalid [HDR_BYTES+1];
   cell_type    cdata [HDR_BYTES+1];
   cell_type    ldata [HDR_BYTES];

   assign source_mac_in = csr_wr_en ? csr_wr_data : source_mac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_mac_ff <= '0;
      end else begin
         source_mac_ff <= source_mac_in;
      end
   end

   always_comb begin
      req.payload_length       = req_tdata[15:0];
      req.addr.source_port     = req_tdata[31:16];
      req.addr.dest_port       = req_tdata[47:32];
      req.addr.source_ip       = req_tdata[79:48];
      req.addr.dest_ip         = req_tdata[111:80];
      req.addr.protocol_number = req_tdata[119:112];
      req.addr.dest_mac        = req_tdata[167:120];
   end

   ehb_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_req    (req),
      .out_valid (frame_valid),
      .out_take  (load),
      .out_frame (frame)
   );

   // The chain moves when the front beat is taken or empty; a new header is
   // loaded once nothing would be left behind the front cell.
   assign shift = !cvalid[0] || rsp_tready;
   assign load  = frame_valid && shift && !cvalid[1];

   assign csum_sum = frame.csum_fold[15:0] + 16'(frame.csum_fold[FOLD_W-1]);
   assign csum     = ~csum_sum;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         hdr[i]      = frame.addr.dest_mac[8*(5-i) +: 8];
         hdr[6 + i]  = source_mac_ff[8*(5-i) +: 8];
      end
      hdr[12] = ETHERTYPE_IPV4[15:8];
      hdr[13] = ETHERTYPE_IPV4[7:0];
      hdr[14] = IP_VER_IHL;
      hdr[15] = IP_TOS;
      hdr[16] = frame.ip_len[15:8];
      hdr[17] = frame.ip_len[7:0];
      hdr[18] = IP_IDENT[15:8];
      hdr[19] = IP_IDENT[7:0];
      hdr[20] = IP_FRAG[15:8];
      hdr[21] = IP_FRAG[7:0];
      hdr[22] = IP_TTL;
      hdr[23] = frame.addr.protocol_number;
      hdr[24] = csum[15:8];
      hdr[25] = csum[7:0];
      for (int i = 0; i < 4; i++) begin
         hdr[26 + i] = frame.addr.source_ip[8*(3-i) +: 8];
         hdr[30 + i] = frame.addr.dest_ip[8*(3-i) +: 8];
      end
      hdr[34] = frame.addr.source_port[15:8];
      hdr[35] = frame.addr.source_port[7:0];
      hdr[36] = frame.addr.dest_port[15:8];
      hdr[37] = frame.addr.dest_port[7:0];
      hdr[38] = frame.udp_len[15:8];
      hdr[39] = frame.udp_len[7:0];
      hdr[40] = UDP_CSUM[15:8];
      hdr[41] = UDP_CSUM[7:0];
   end

   assign cvalid[HDR_BYTES] = 1'b0;
   assign cdata[HDR_BYTES]  = '0;

   for (genvar g = 0; g < HDR_BYTES; g++) begin : g_cell
      assign ldata[g].data = hdr[g];
      assign ldata[g].pos  = POS_W'(g);
      assign ldata[g].last = (g == HDR_BYTES - 1);

      ehb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (shift),
         .load       (load),
         .load_data  (ldata[g]),
         .next_valid (cvalid[g+1]),
         .next_data  (cdata[g+1]),
         .cell_valid (cvalid[g]),
         .cell_data  (cdata[g])
      );
   end

   assign rsp_tvalid = cvalid[0];
   assign rsp_tdata  = {2'b00, cdata[0].pos, cdata[0].data};
   assign rsp_tlast  = cdata[0].last;

endmodule
`default_nettype wire

// ===== src/ehb_checker.sv =====
// Port-level checks on the header builder, attached to the top level by bind.
// Depends on eth_ipv4_udp_header_builder_assert.svh.
`default_nettype none
`include "eth_ipv4_udp_header_builder_assert.svh"
module ehb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // A stalled result beat must not change.
   `EHB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled rsp beat changed")

   // Within a header the beats are contiguous and the offset counts up by one.
   `EHB_ASSERT_NEXT(a_pos_step, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && (rsp_tdata[13:8] == 6'($past(rsp_tdata[13:8]) + 6'd1)), "header offset did not advance")

   // The last beat is exactly the one at offset 41.
   `EHB_ASSERT(a_last_pos, rsp_tvalid, rsp_tlast == (rsp_tdata[13:8] == 6'd41), "tlast and offset disagree")

   // A new header starts at offset zero.
   `EHB_ASSERT_NEXT(a_frame_start, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid || (rsp_tdata[13:8] == 6'd0), "header did not start at offset zero")

   // A request taken while the output is idle reaches the output once it has passed the prep stages and the byte chain.
   `EHB_ASSERT(a_req_latency, req_tvalid && req_tready && !rsp_tvalid, ##3 rsp_tvalid, "request did not reach the output")

endmodule

bind eth_ipv4_udp_header_builder ehb_checker u_ehb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
